FILE: design/mseu_pkg.sv
// ----------------------------------------------------------------------------
// mseu_pkg
// Shared widths, operation codes and defaults of the scalar execute unit.
// ----------------------------------------------------------------------------
package mseu_pkg;

   localparam int DMEM_BYTES_DEFAULT = 4096;

   localparam int OP_W    = 6;
   localparam int INSTR_W = 32;
   localparam int PC_W    = 12;
   localparam int REG_W   = 32;
   localparam int RIDX_W  = 5;

   typedef logic [OP_W-1:0]    op_type;
   typedef logic [INSTR_W-1:0] instr_type;
   typedef logic [PC_W-1:0]    pc_type;
   typedef logic [REG_W-1:0]   word_type;
   typedef logic [RIDX_W-1:0]  ridx_type;

   localparam op_type OP_NONE     = 6'd0;
   localparam op_type OP_SLL      = 6'd1;
   localparam op_type OP_SRL      = 6'd2;
   localparam op_type OP_SRA      = 6'd3;
   localparam op_type OP_SLLV     = 6'd4;
   localparam op_type OP_SRLV     = 6'd5;
   localparam op_type OP_SRAV     = 6'd6;
   localparam op_type OP_JR       = 6'd7;
   localparam op_type OP_JALR     = 6'd8;
   localparam op_type OP_BREAK    = 6'd9;
   localparam op_type OP_ADDU     = 6'd10;
   localparam op_type OP_SUBU     = 6'd11;
   localparam op_type OP_AND      = 6'd12;
   localparam op_type OP_OR       = 6'd13;
   localparam op_type OP_XOR      = 6'd14;
   localparam op_type OP_NOR      = 6'd15;
   localparam op_type OP_SLT      = 6'd16;
   localparam op_type OP_SLTU     = 6'd17;
   localparam op_type OP_BLTZ     = 6'd18;
   localparam op_type OP_BGEZ     = 6'd19;
   localparam op_type OP_BLTZAL   = 6'd20;
   localparam op_type OP_BGEZAL   = 6'd21;
   localparam op_type OP_J        = 6'd22;
   localparam op_type OP_JAL      = 6'd23;
   localparam op_type OP_BEQ      = 6'd24;
   localparam op_type OP_BNE      = 6'd25;
   localparam op_type OP_BLEZ     = 6'd26;
   localparam op_type OP_BGTZ     = 6'd27;
   localparam op_type OP_ADDIU    = 6'd28;
   localparam op_type OP_SLTI     = 6'd29;
   localparam op_type OP_SLTIU    = 6'd30;
   localparam op_type OP_ANDI     = 6'd31;
   localparam op_type OP_ORI      = 6'd32;
   localparam op_type OP_XORI     = 6'd33;
   localparam op_type OP_LUI      = 6'd34;
   localparam op_type OP_COP0     = 6'd35;
   localparam op_type OP_COP2     = 6'd36;
   localparam op_type OP_LB       = 6'd37;
   localparam op_type OP_LH       = 6'd38;
   localparam op_type OP_LW       = 6'd39;
   localparam op_type OP_LBU      = 6'd40;
   localparam op_type OP_LHU      = 6'd41;
   localparam op_type OP_SB       = 6'd42;
   localparam op_type OP_SH       = 6'd43;
   localparam op_type OP_SW       = 6'd44;
   localparam op_type OP_VLOAD    = 6'd45;
   localparam op_type OP_VSTORE   = 6'd46;
   localparam op_type OP_RSV_SPEC = 6'd47;

   localparam ridx_type LINK_REG = 5'd31;

   // load kinds
   localparam logic [2:0] LD_B  = 3'd0;
   localparam logic [2:0] LD_H  = 3'd1;
   localparam logic [2:0] LD_W  = 3'd2;
   localparam logic [2:0] LD_BU = 3'd3;
   localparam logic [2:0] LD_HU = 3'd4;

endpackage

FILE: design/mseu_req_if.sv
// ----------------------------------------------------------------------------
// mseu_req_if
// Instruction channel: decoded op, raw instruction word and program counter.
// ----------------------------------------------------------------------------
interface mseu_req_if;
   import mseu_pkg::*;

   logic      valid;
   logic      ready;
   op_type    op;
   instr_type instruction;
   pc_type    pc;

   modport source (output valid, output op, output instruction, output pc, input ready);
   modport sink   (input valid, input op, input instruction, input pc, output ready);
endinterface

FILE: design/mseu_rsp_if.sv
// ----------------------------------------------------------------------------
// mseu_rsp_if
// Result channel: register write, branch outcome and status flags.
// ----------------------------------------------------------------------------
interface mseu_rsp_if;
   import mseu_pkg::*;

   logic     valid;
   logic     ready;
   logic     reg_write;
   ridx_type reg_index;
   word_type reg_value;
   logic     branch_taken;
   pc_type   target_pc;
   logic     break_hit;
   logic     interrupt_request;
   logic     forwarded;

   modport source (output valid, output reg_write, output reg_index, output reg_value,
                   output branch_taken, output target_pc, output break_hit,
                   output interrupt_request, output forwarded, input ready);
   modport sink   (input valid, input reg_write, input reg_index, input reg_value,
                   input branch_taken, input target_pc, input break_hit,
                   input interrupt_request, input forwarded, output ready);
endinterface

FILE: design/mseu_csr_if.sv
// ----------------------------------------------------------------------------
// mseu_csr_if
// Configuration write channel carrying the interrupt-on-break bit.
// ----------------------------------------------------------------------------
interface mseu_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/mips_scalar_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_scalar_execute_unit
// Scalar integer execute unit with register file and banked data memory.
// ----------------------------------------------------------------------------
// req_bus carries one decoded instruction per transaction; rsp_bus returns
// exactly one result transaction for each, in order. csr_bus writes the
// interrupt-on-break bit and is always ready.
// The register file is read at accept; the operation and the data memory
// access happen as the item moves from the input stage to the output stage,
// where the result is held. Throughput is one transaction per cycle while
// rsp_bus is ready.
// Register results are forwarded from the output stage and from the last
// committed write, so dependent instructions issue back to back.
// The data memory is four byte-wide banks; an access of up to four bytes
// touches each bank once, unaligned addresses wrap modulo DMEM_BYTES
// (a power of two).
// After reset the register file reads zero via valid bits, and a clearing
// pass over the DMEM_BYTES/4 rows zeroes the data memory; req_bus.ready stays
// low during it. A stalled rsp_bus holds its result; one more instruction
// is still accepted before req_bus.ready drops.
// ----------------------------------------------------------------------------
module mips_scalar_execute_unit #(
   parameter int DMEM_BYTES = mseu_pkg::DMEM_BYTES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mseu_req_if.sink   req_bus,
   mseu_rsp_if.source rsp_bus,
   mseu_csr_if.sink   csr_bus
);
   import mseu_pkg::*;

   localparam int AW   = $clog2(DMEM_BYTES);
   localparam int ROWS = DMEM_BYTES / 4;
   localparam int RW   = AW - 2;

   // configuration
   logic irq_en_ff;
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         irq_en_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         irq_en_ff <= csr_bus.data;
      end
   end

   // clearing pass
   logic          clr_ff;
   logic [RW-1:0] clr_row_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_row_ff <= '0;
      end else if (clr_ff) begin
         clr_row_ff <= clr_row_ff + 1'b1;
         if (clr_row_ff == RW'(ROWS - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // pipeline control
   logic s1_v_ff, s2_v_ff, s1_fresh_ff;
   logic s2_en, s1_en, s1_adv, accept;
   assign s2_en   = !s2_v_ff || rsp_bus.ready;
   assign s1_en   = !s1_v_ff || s2_en;
   assign s1_adv  = s1_v_ff && s2_en;
   assign req_bus.ready = s1_en && !clr_ff;
   assign accept  = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s1_fresh_ff <= 1'b0;
      end else begin
         s1_fresh_ff <= accept;
         if (accept) begin
            s1_v_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_v_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            s2_v_ff <= 1'b0;
         end
      end
   end

   // stage 1 item
   op_type    s1_op_ff;
   instr_type s1_ins_ff;
   pc_type    s1_pc_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff  <= req_bus.op;
         s1_ins_ff <= req_bus.instruction;
         s1_pc_ff  <= req_bus.pc;
      end
   end

   ridx_type rs, rt, rd;
   logic [4:0] sa;
   logic [15:0] uimm;
   word_type simm;
   assign rs   = s1_ins_ff[25:21];
   assign rt   = s1_ins_ff[20:16];
   assign rd   = s1_ins_ff[15:11];
   assign sa   = s1_ins_ff[10:6];
   assign uimm = s1_ins_ff[15:0];
   assign simm = {{16{uimm[15]}}, uimm};

   // register file
   word_type rf_mem [32];
   logic [31:0] rf_vld_ff;
   word_type rf_qa_ff, rf_qb_ff;
   logic     rf_va_ff, rf_vb_ff;
   logic     rf_we;
   ridx_type s2_idx_ff;
   word_type s2_value;

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[s2_idx_ff] <= s2_value;
      end
      if (accept) begin
         rf_qa_ff <= rf_mem[req_bus.instruction[25:21]];
         rf_qb_ff <= rf_mem[req_bus.instruction[20:16]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
         rf_va_ff  <= 1'b0;
         rf_vb_ff  <= 1'b0;
      end else begin
         if (rf_we) begin
            rf_vld_ff[s2_idx_ff] <= 1'b1;
         end
         if (accept) begin
            rf_va_ff <= rf_vld_ff[req_bus.instruction[25:21]];
            rf_vb_ff <= rf_vld_ff[req_bus.instruction[20:16]];
         end
      end
   end

   // last committed write, seen by the item read at the same edge
   logic     lw_v_ff;
   ridx_type lw_idx_ff;
   word_type lw_val_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_v_ff <= 1'b0;
      end else begin
         lw_v_ff <= rf_we;
      end
      lw_idx_ff <= s2_idx_ff;
      lw_val_ff <= s2_value;
   end

   // operand forwarding
   logic     s2_wr_ff;
   word_type a_hold_ff, b_hold_ff, a_hold_in, b_hold_in;
   word_type base_a, base_b, opa, opb;
   always_comb begin
      if (s1_fresh_ff) begin
         base_a = (lw_v_ff && lw_idx_ff == rs) ? lw_val_ff : (rf_va_ff ? rf_qa_ff : '0);
         base_b = (lw_v_ff && lw_idx_ff == rt) ? lw_val_ff : (rf_vb_ff ? rf_qb_ff : '0);
      end else begin
         base_a = a_hold_ff;
         base_b = b_hold_ff;
      end
      opa       = (s2_v_ff && s2_wr_ff && s2_idx_ff == rs) ? s2_value : base_a;
      opb       = (s2_v_ff && s2_wr_ff && s2_idx_ff == rt) ? s2_value : base_b;
      a_hold_in = (rf_we && s2_idx_ff == rs) ? s2_value : base_a;
      b_hold_in = (rf_we && s2_idx_ff == rt) ? s2_value : base_b;
   end

   always_ff @(posedge clock) begin
      a_hold_ff <= a_hold_in;
      b_hold_ff <= b_hold_in;
   end

   // execute
   logic       x_wr, x_br, x_brk, x_irq, x_fwd, x_ld, x_st;
   ridx_type   x_idx;
   word_type   x_val;
   pc_type     x_tgt, btgt, link;
   logic [2:0] x_ldk;
   logic [2:0] x_size;
   word_type   ea;

   assign btgt = (s1_pc_ff + 12'd4 + {uimm[9:0], 2'b00}) & 12'hffc;
   assign link = (s1_pc_ff + 12'd8) & 12'hffc;
   assign ea   = opa + simm;

   always_comb begin
      x_wr   = 1'b0;
      x_idx  = rd;
      x_val  = '0;
      x_br   = 1'b0;
      x_tgt  = btgt;
      x_brk  = 1'b0;
      x_irq  = 1'b0;
      x_fwd  = 1'b0;
      x_ld   = 1'b0;
      x_st   = 1'b0;
      x_ldk  = LD_W;
      x_size = 3'd4;
      unique case (s1_op_ff)
         OP_SLL:  begin x_wr = 1'b1; x_val = opb << sa; end
         OP_SRL:  begin x_wr = 1'b1; x_val = opb >> sa; end
         OP_SRA:  begin x_wr = 1'b1; x_val = word_type'($signed(opb) >>> sa); end
         OP_SLLV: begin x_wr = 1'b1; x_val = opb << opa[4:0]; end
         OP_SRLV: begin x_wr = 1'b1; x_val = opb >> opa[4:0]; end
         OP_SRAV: begin x_wr = 1'b1; x_val = word_type'($signed(opb) >>> opa[4:0]); end
         OP_JR:   begin x_br = 1'b1; x_tgt = {opa[11:2], 2'b00}; end
         OP_JALR: begin
            x_wr = 1'b1; x_val = word_type'(link);
            x_br = 1'b1; x_tgt = {opa[11:2], 2'b00};
         end
         OP_BREAK: begin x_brk = 1'b1; x_irq = irq_en_ff; end
         OP_ADDU: begin x_wr = 1'b1; x_val = opa + opb; end
         OP_SUBU: begin x_wr = 1'b1; x_val = opa - opb; end
         OP_AND:  begin x_wr = 1'b1; x_val = opa & opb; end
         OP_OR:   begin x_wr = 1'b1; x_val = opa | opb; end
         OP_XOR:  begin x_wr = 1'b1; x_val = opa ^ opb; end
         OP_NOR:  begin x_wr = 1'b1; x_val = ~(opa | opb); end
         OP_SLT:  begin x_wr = 1'b1; x_val = word_type'($signed(opa) < $signed(opb)); end
         OP_SLTU: begin x_wr = 1'b1; x_val = word_type'(opa < opb); end
         OP_BLTZ: x_br = opa[31];
         OP_BGEZ: x_br = !opa[31];
         OP_BLTZAL: begin
            x_wr = 1'b1; x_idx = LINK_REG; x_val = word_type'(link); x_br = opa[31];
         end
         OP_BGEZAL: begin
            x_wr = 1'b1; x_idx = LINK_REG; x_val = word_type'(link); x_br = !opa[31];
         end
         OP_J:    begin x_br = 1'b1; x_tgt = {s1_ins_ff[9:0], 2'b00}; end
         OP_JAL:  begin
            x_wr = 1'b1; x_idx = LINK_REG; x_val = word_type'(link);
            x_br = 1'b1; x_tgt = {s1_ins_ff[9:0], 2'b00};
         end
         OP_BEQ:  x_br = (opa == opb);
         OP_BNE:  x_br = (opa != opb);
         OP_BLEZ: x_br = (opa == '0) || opa[31];
         OP_BGTZ: x_br = (opa != '0) && !opa[31];
         OP_ADDIU: begin x_wr = 1'b1; x_idx = rt; x_val = opa + simm; end
         OP_SLTI:  begin
            x_wr = 1'b1; x_idx = rt; x_val = word_type'($signed(opa) < $signed(simm));
         end
         OP_SLTIU: begin x_wr = 1'b1; x_idx = rt; x_val = word_type'(opa < simm); end
         OP_ANDI:  begin x_wr = 1'b1; x_idx = rt; x_val = opa & {16'd0, uimm}; end
         OP_ORI:   begin x_wr = 1'b1; x_idx = rt; x_val = opa | {16'd0, uimm}; end
         OP_XORI:  begin x_wr = 1'b1; x_idx = rt; x_val = opa ^ {16'd0, uimm}; end
         OP_LUI:   begin x_wr = 1'b1; x_idx = rt; x_val = {uimm, 16'd0}; end
         OP_COP0, OP_COP2, OP_VLOAD, OP_VSTORE: x_fwd = 1'b1;
         OP_LB:  begin x_wr = 1'b1; x_idx = rt; x_ld = 1'b1; x_ldk = LD_B;  x_size = 3'd1; end
         OP_LH:  begin x_wr = 1'b1; x_idx = rt; x_ld = 1'b1; x_ldk = LD_H;  x_size = 3'd2; end
         OP_LW:  begin x_wr = 1'b1; x_idx = rt; x_ld = 1'b1; x_ldk = LD_W;  x_size = 3'd4; end
         OP_LBU: begin x_wr = 1'b1; x_idx = rt; x_ld = 1'b1; x_ldk = LD_BU; x_size = 3'd1; end
         OP_LHU: begin x_wr = 1'b1; x_idx = rt; x_ld = 1'b1; x_ldk = LD_HU; x_size = 3'd2; end
         OP_SB:  begin x_st = 1'b1; x_size = 3'd1; end
         OP_SH:  begin x_st = 1'b1; x_size = 3'd2; end
         OP_SW:  begin x_st = 1'b1; x_size = 3'd4; end
         OP_RSV_SPEC: begin x_wr = 1'b1; x_val = opa >> opa[4:0]; end
         default: ;
      endcase
      if (x_idx == '0) begin
         x_wr = 1'b0;
      end
   end

   // data memory: four byte banks
   logic [7:0] bank_q_ff [4];
   genvar k;
   generate
      for (k = 0; k < 4; k++) begin : g_bank
         logic [7:0]    mem [ROWS];
         logic [1:0]    off;
         logic [AW-1:0] baddr;
         logic [RW-1:0] row;
         logic [1:0]    sh;
         logic          we;
         logic [7:0]    wdata;
         assign off   = 2'(k) - ea[1:0];
         assign baddr = ea[AW-1:0] + AW'(off);
         assign row   = baddr[AW-1:2];
         assign sh    = 2'(x_size - 3'd1 - {1'b0, off});
         assign we    = s1_adv && x_st && ({1'b0, off} < x_size);
         assign wdata = opb[8*sh +: 8];
         always_ff @(posedge clock) begin
            if (clr_ff) begin
               mem[clr_row_ff] <= 8'd0;
            end else if (we) begin
               mem[row] <= wdata;
            end
            if (s1_adv && x_ld) begin
               bank_q_ff[k] <= mem[row];
            end
         end
      end
   endgenerate

   // stage 2 / output
   logic       s2_br_ff, s2_brk_ff, s2_irq_ff, s2_fwd_ff, s2_ld_ff;
   word_type   s2_val_ff;
   pc_type     s2_tgt_ff;
   logic [2:0] s2_ldk_ff;
   logic [1:0] s2_ea_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_wr_ff  <= x_wr;
         s2_idx_ff <= x_wr ? x_idx : '0;
         s2_val_ff <= x_wr ? x_val : '0;
         s2_br_ff  <= x_br;
         s2_tgt_ff <= x_br ? x_tgt : '0;
         s2_brk_ff <= x_brk;
         s2_irq_ff <= x_irq;
         s2_fwd_ff <= x_fwd;
         s2_ld_ff  <= x_ld && x_wr;
         s2_ldk_ff <= x_ldk;
         s2_ea_ff  <= ea[1:0];
      end
   end

   logic [7:0] by0, by1, by2, by3;
   word_type   ld_val;
   assign by0 = bank_q_ff[s2_ea_ff];
   assign by1 = bank_q_ff[2'(s2_ea_ff + 2'd1)];
   assign by2 = bank_q_ff[2'(s2_ea_ff + 2'd2)];
   assign by3 = bank_q_ff[2'(s2_ea_ff + 2'd3)];
   always_comb begin
      unique case (s2_ldk_ff)
         LD_B:    ld_val = {{24{by0[7]}}, by0};
         LD_H:    ld_val = {{16{by0[7]}}, by0, by1};
         LD_BU:   ld_val = {24'd0, by0};
         LD_HU:   ld_val = {16'd0, by0, by1};
         default: ld_val = {by0, by1, by2, by3};
      endcase
   end

   assign s2_value = s2_ld_ff ? ld_val : s2_val_ff;
   assign rf_we    = s2_v_ff && s2_wr_ff && rsp_bus.ready;

   assign rsp_bus.valid             = s2_v_ff;
   assign rsp_bus.reg_write         = s2_wr_ff;
   assign rsp_bus.reg_index         = s2_idx_ff;
   assign rsp_bus.reg_value         = s2_value;
   assign rsp_bus.branch_taken      = s2_br_ff;
   assign rsp_bus.target_pc         = s2_tgt_ff;
   assign rsp_bus.break_hit         = s2_brk_ff;
   assign rsp_bus.interrupt_request = s2_irq_ff;
   assign rsp_bus.forwarded         = s2_fwd_ff;

endmodule
